>>> rtl/core/ssirl_pkg.sv
`default_nettype none

package ssirl_pkg;

    // Store geometry
    localparam int unsigned CAPACITY = 64;
    localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the transfer payloads
    localparam int unsigned OP_W     = 2;
    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned OCNT_W   = 7;

    // Request codes; the unused code behaves as a lookup
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // One access cycle to the element store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

endpackage

`default_nettype wire

>>> rtl/core/ssirl_store.sv
`default_nettype none

module ssirl_store (
    input  wire logic                             i_clk,
    input  wire ssirl_pkg::t_store_req            i_req,
    output logic [ssirl_pkg::ELEM_W-1:0]          o_rdata
);

    logic [ssirl_pkg::ELEM_W-1:0] r_mem [ssirl_pkg::CAPACITY];
    logic [ssirl_pkg::ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/small_set_insert_remove_lookup.sv
`default_nettype none

// Unordered set of up to CAPACITY distinct 32-bit elements. Each request
// (lookup, insert or remove) gives one result: whether the element was held
// before, whether an insert was refused for lack of room, and the count of
// elements held afterwards. Elements live in a single-port-read,
// single-port-write synchronous memory; the block scans it one entry per
// cycle from slot 0 up to the current count, stopping at the first match.
// A remove moves the last held entry into the freed slot, an insert appends
// at the end. One request is in work at a time: it is accepted, scans the
// entries through the registered read port and then finishes; a remove that
// hits adds a read and a write back of the last entry before it finishes.
// A new request is taken as soon as the previous one has finished, even
// while its result still waits on o_valid; the finishing step holds only if
// that earlier result has not yet been taken. No clearing pass is needed
// after reset: entries at or above the count are never read.

module small_set_insert_remove_lookup (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [ssirl_pkg::OP_W-1:0]       i_op,
    input  wire logic signed [ssirl_pkg::ELEM_W-1:0] i_element,
    // result channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_found,
    output logic                                  o_full_res,
    output logic [ssirl_pkg::OCNT_W-1:0]          o_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST_RD,
        S_LAST_WR,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [ssirl_pkg::OP_W-1:0]      r_op;
    logic [ssirl_pkg::ELEM_W-1:0]    r_elem;
    logic [ssirl_pkg::CNT_W-1:0]     r_count;
    logic [ssirl_pkg::CNT_W-1:0]     r_rd_idx;   // next slot to read
    logic                            r_chk_valid; // read data due this cycle
    logic [ssirl_pkg::ADDR_W-1:0]    r_chk_idx;  // slot of that read data
    logic                            r_hit;
    logic [ssirl_pkg::ADDR_W-1:0]    r_slot;

    logic                            r_out_valid;
    logic                            r_found;
    logic                            r_full;
    logic [ssirl_pkg::OCNT_W-1:0]    r_out_count;

    ssirl_pkg::t_store_req           store_req;
    logic [ssirl_pkg::ELEM_W-1:0]    store_rdata;

    logic                            in_xfer;
    logic                            out_free;
    logic                            scan_issue;
    logic                            chk_match;
    logic                            chk_last;
    logic                            is_insert;
    logic                            is_remove;
    logic                            room;
    logic [ssirl_pkg::CNT_W-1:0]     last_cnt;

    assign in_xfer   = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign is_insert = (r_op == ssirl_pkg::OP_INSERT);
    assign is_remove = (r_op == ssirl_pkg::OP_REMOVE);
    assign room      = (r_count < ssirl_pkg::CNT_W'(ssirl_pkg::CAPACITY));
    assign last_cnt  = r_count - ssirl_pkg::CNT_W'(1);

    assign scan_issue = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign chk_match  = r_chk_valid && (store_rdata == r_elem);
    assign chk_last   = r_chk_valid
                        && (ssirl_pkg::CNT_W'(r_chk_idx) == last_cnt);

    // Memory access per state
    always_comb begin
        store_req       = '0;
        store_req.wdata = r_elem;
        store_req.waddr = r_count[ssirl_pkg::ADDR_W-1:0];
        store_req.raddr = r_rd_idx[ssirl_pkg::ADDR_W-1:0];
        case (r_state)
            S_SCAN: begin
                store_req.re = scan_issue;
            end
            S_LAST_RD: begin
                // fetch the last held entry to fill the freed slot
                store_req.re    = 1'b1;
                store_req.raddr = last_cnt[ssirl_pkg::ADDR_W-1:0];
            end
            S_LAST_WR: begin
                store_req.we    = 1'b1;
                store_req.waddr = r_slot;
                store_req.wdata = store_rdata;
            end
            S_DONE: begin
                // append on an insert of an absent element with room left
                store_req.we = out_free && is_insert && !r_hit && room;
            end
            default: begin
                store_req = '0;
            end
        endcase
    end

    ssirl_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_chk_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            // result held until taken, then refilled by the finishing step
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op        <= i_op;
                        r_elem      <= i_element;
                        r_rd_idx    <= '0;
                        r_chk_valid <= 1'b0;
                        r_hit       <= 1'b0;
                        r_state     <= (r_count == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_chk_valid <= scan_issue && !chk_match && !chk_last;
                    r_chk_idx   <= r_rd_idx[ssirl_pkg::ADDR_W-1:0];
                    if (scan_issue) begin
                        r_rd_idx <= r_rd_idx + ssirl_pkg::CNT_W'(1);
                    end
                    if (chk_match) begin
                        r_hit       <= 1'b1;
                        r_slot      <= r_chk_idx;
                        r_state     <= is_remove ? S_LAST_RD : S_DONE;
                    end else if (chk_last) begin
                        r_state     <= S_DONE;
                    end
                end
                S_LAST_RD: begin
                    r_state <= S_LAST_WR;
                end
                S_LAST_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_found     <= r_hit;
                        r_full      <= is_insert && !r_hit && !room;
                        if (is_insert && !r_hit && room) begin
                            r_count     <= r_count + ssirl_pkg::CNT_W'(1);
                            r_out_count <= ssirl_pkg::OCNT_W'(
                                r_count + ssirl_pkg::CNT_W'(1));
                        end else if (is_remove && r_hit) begin
                            r_count     <= last_cnt;
                            r_out_count <= ssirl_pkg::OCNT_W'(last_cnt);
                        end else begin
                            r_out_count <= ssirl_pkg::OCNT_W'(r_count);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_full_res = r_full;
    assign o_count    = r_out_count;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ssirl_pkg::*;

    // op 3 has no name in the package; the block treats it as a lookup
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int POOL_SIZE    = 72;   // a little above capacity, so fills overflow
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off for back-pressure
    localparam int QUIET_LIMIT  = 3000; // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 80;   // settle time for stray late results before judging

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ELEM_W-1:0] element;
    } set_request_t;

    typedef struct packed {
        logic              found;
        logic              full;
        logic [OCNT_W-1:0] count;
    } set_result_t;

    // DUT ports; every input starts at a known value
    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic                     o_stall;
    logic [OP_W-1:0]          i_op       = OP_LOOKUP;
    logic signed [ELEM_W-1:0] i_element  = '0;
    logic                     o_valid;
    logic                     i_stall    = 1'b0;
    logic                     o_found;
    logic                     o_full_res;
    logic [OCNT_W-1:0]        o_count;

    // Stimulus and scoreboard
    set_request_t      pending_requests[$];
    set_result_t       expected_results[$];
    logic [ELEM_W-1:0] elem_pool[POOL_SIZE];

    // Our own copy of the set, advanced on every accepted request transfer
    logic [ELEM_W-1:0] held_elems[CAPACITY];
    int                held_count = 0;

    // Idling controls; the percentages and hold_requests change only between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    int error_count = 0;
    int quiet_cycles = 0;

    small_set_insert_remove_lookup dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_element  (i_element),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_full_res (o_full_res),
        .o_count    (o_count)
    );

    always #4 i_clk = ~i_clk;

    // Set behaviour: linear search from slot 0, append on insert, and on a
    // remove the last held entry is moved into the freed slot.
    function automatic set_result_t apply_request(logic [OP_W-1:0] op,
                                                  logic [ELEM_W-1:0] elem);
        set_result_t r;
        int          slot;
        logic        hit;
        slot = held_count;
        hit  = 1'b0;
        for (int k = 0; k < held_count; k++) begin
            if (!hit && held_elems[k] == elem) begin
                slot = k;
                hit  = 1'b1;
            end
        end
        r.found = hit;
        r.full  = 1'b0;
        case (op)
            OP_INSERT: begin
                if (!hit) begin
                    if (held_count >= CAPACITY) begin
                        r.full = 1'b1;    // refused, store unchanged
                    end else begin
                        held_elems[held_count] = elem;
                        held_count++;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    // removing the last entry copies it onto itself
                    held_elems[slot] = held_elems[held_count-1];
                    held_count--;
                end
            end
            default: ;                    // lookup, and the unused code
        endcase
        r.count = OCNT_W'(held_count);
        return r;
    endfunction

    // Driver: a new request may be presented when the line is free or the
    // current one transfers at this edge; a stalled request is held as is.
    always @(posedge i_clk) begin
        set_request_t req;
        set_result_t  exp_new;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                exp_new = apply_request(i_op, i_element);
                expected_results.insert(expected_results.size(), exp_new);
            end
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    i_valid   <= 1'b1;
                    i_op      <= req.op;
                    i_element <= req.element;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation,
    // and drives the result stall (random, or a long counted hold-off).
    always @(posedge i_clk) begin
        set_result_t exp_res;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result found=%0b full=%0b count=%0d",
                             $time, o_found, o_full_res, o_count);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_found !== exp_res.found || o_full_res !== exp_res.full ||
                        o_count !== exp_res.count) begin
                        $display("%0t: exp %0b/%0b/%0d got %0b/%0b/%0d (found/full/count)",
                                 $time, exp_res.found, exp_res.full, exp_res.count,
                                 o_found, o_full_res, o_count);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_requests != hold_served) begin
                hold_served <= hold_requests;
                hold_left   <= HOLD_CYCLES - 1;
                i_stall     <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_request(logic [OP_W-1:0] op, logic [ELEM_W-1:0] elem);
        set_request_t req;
        req.op      = op;
        req.element = elem;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Fresh working set per phase; the extremes are always in it
    task automatic refresh_pool();
        elem_pool[0] = 32'h8000_0000;
        elem_pool[1] = 32'h7fff_ffff;
        elem_pool[2] = 32'h0000_0000;
        elem_pool[3] = 32'hffff_ffff;
        for (int k = 4; k < POOL_SIZE; k++) elem_pool[k] = $urandom;
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        case ($urandom_range(2))
            0:       return OP_LOOKUP;
            1:       return OP_INSERT;
            default: return OP_REMOVE;
        endcase
    endfunction

    // Mostly well-formed sequences over the pool: fills past capacity,
    // drains, mixed traffic; the rest is unknown ops and fresh values.
    // Each burst is cut short so that exactly n requests are queued.
    task automatic queue_random_requests(int n);
        int added;
        int kind;
        int len;
        int start;
        added = 0;
        refresh_pool();
        while (added < n) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                start = $urandom_range(POOL_SIZE - 1);
                len = (n - added < POOL_SIZE) ? n - added : POOL_SIZE;
                for (int k = 0; k < len; k++)
                    push_request(OP_INSERT, elem_pool[(start + k) % POOL_SIZE]);
                added += len;
            end else if (kind < 35) begin
                len = $urandom_range(60, 20);
                if (len > n - added) len = n - added;
                for (int k = 0; k < len; k++)
                    push_request(OP_REMOVE, elem_pool[$urandom_range(POOL_SIZE - 1)]);
                added += len;
            end else if (kind < 80) begin
                len = $urandom_range(30, 10);
                if (len > n - added) len = n - added;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(4) == 0)
                        push_request(pick_op(), $urandom);
                    else
                        push_request(pick_op(), elem_pool[$urandom_range(POOL_SIZE - 1)]);
                end
                added += len;
            end else begin
                len = $urandom_range(5, 1);
                if (len > n - added) len = n - added;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(1) == 0)
                        push_request(OP_UNUSED, elem_pool[$urandom_range(POOL_SIZE - 1)]);
                    else
                        push_request(pick_op(), $urandom);
                end
                added += len;
            end
        end
    endtask

    // Everything offered has transferred and every result has been checked
    task automatic wait_for_quiet();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty store, extremes, duplicate insert, unknown op,
        // absent remove, remove of the last entry and of the first slot.
        push_request(OP_LOOKUP, 32'h0000_0000);
        push_request(OP_REMOVE, 32'h0000_0005);
        push_request(OP_UNUSED, 32'h0000_0000);
        push_request(OP_INSERT, 32'h8000_0000);
        push_request(OP_INSERT, 32'h7fff_ffff);
        push_request(OP_INSERT, 32'h0000_0000);
        push_request(OP_INSERT, 32'hffff_ffff);
        push_request(OP_INSERT, 32'h7fff_ffff);
        push_request(OP_LOOKUP, 32'hffff_ffff);
        push_request(OP_LOOKUP, 32'h5555_5555);
        push_request(OP_UNUSED, 32'h8000_0000);
        push_request(OP_UNUSED, 32'haaaa_aaaa);
        push_request(OP_REMOVE, 32'haaaa_aaaa);
        push_request(OP_REMOVE, 32'hffff_ffff);
        push_request(OP_REMOVE, 32'h8000_0000);
        push_request(OP_LOOKUP, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'h7fff_ffff);
        push_request(OP_INSERT, 32'h5555_5555);
        push_request(OP_INSERT, 32'haaaa_aaaa);
        push_request(OP_REMOVE, 32'h0000_0000);
        push_request(OP_REMOVE, 32'h7fff_ffff);
        push_request(OP_REMOVE, 32'h5555_5555);
        push_request(OP_REMOVE, 32'haaaa_aaaa);
        push_request(OP_LOOKUP, 32'haaaa_aaaa);
        wait_for_quiet();

        // Back to back, with one long hold-off while requests keep coming
        queue_random_requests(130);
        hold_requests++;
        wait_for_quiet();

        send_idle_pct  = 59;
        recv_stall_pct = 0;
        queue_random_requests(170);
        wait_for_quiet();

        send_idle_pct  = 0;
        recv_stall_pct = 59;
        queue_random_requests(170);
        wait_for_quiet();

        send_idle_pct  = 25;
        recv_stall_pct = 25;
        queue_random_requests(180);
        wait_for_quiet();

        // Let any stray late result show up before judging
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ssirl_pkg.sv
rtl/core/ssirl_store.sv
rtl/core/small_set_insert_remove_lookup.sv
sim/tb.sv
